@@ rtl/core/pcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcrc_pkg: shared types and codes for the programmable CRC encoder/checker
// Holds the channel payload structs, the command passed from the front end
// to the back end, and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GENERATOR_LOW = 2'd0;
    localparam logic [1:0] CFG_DEGREE        = 2'd1;
    localparam logic [1:0] CFG_MODE          = 2'd2;

    localparam int GEN_W    = 32;
    localparam int DEGREE_W = 6;

    localparam logic [GEN_W-1:0]    GEN_RESET    = 32'd7;
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 6'd8;
    localparam logic                MODE_RESET   = 1'b0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    // Command kinds decided by the front end
    localparam logic [1:0] KIND_ECHO       = 2'd0;
    localparam logic [1:0] KIND_ECHO_LAST  = 2'd1;
    localparam logic [1:0] KIND_CHECK      = 2'd2;
    localparam logic [1:0] KIND_CHECK_LAST = 2'd3;

    typedef struct packed {
        logic data_bit;
        logic last_bit;
    } in_t;

    typedef struct packed {
        logic out_bit;
        logic is_remainder;
        logic check_ok;
        logic frame_end;
    } out_t;

    typedef struct packed {
        logic       data_bit;
        logic [1:0] kind;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pcrc_front.sv @@
// ----------------------------------------------------------------------------
// pcrc_front: request intake and classification
// Tags each accepted bit with its command kind from the mode and the last
// flag, and buffers it in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          mode,
    input  wire logic          bit_valid,
    output logic               bit_ready,
    input  wire pcrc_pkg::in_t bit_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output pcrc_pkg::cmd_t     q_cmd
);

    localparam int DEPTH = 2;

    pcrc_pkg::cmd_t fifo_reg [DEPTH];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;
    pcrc_pkg::cmd_t cmd_in;

    always_comb
    begin
        cmd_in.data_bit = bit_data.data_bit;
        if (mode == pcrc_pkg::MODE_CHECK)
        begin
            cmd_in.kind = bit_data.last_bit ? pcrc_pkg::KIND_CHECK_LAST
                                            : pcrc_pkg::KIND_CHECK;
        end
        else
        begin
            cmd_in.kind = bit_data.last_bit ? pcrc_pkg::KIND_ECHO_LAST
                                            : pcrc_pkg::KIND_ECHO;
        end
    end

    assign bit_ready = (count_reg != 2'(DEPTH));
    assign q_valid   = (count_reg != 2'd0);
    assign q_cmd     = fifo_reg[rd_ptr_reg];
    assign push      = bit_valid && bit_ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pcrc_back.sv @@
// ----------------------------------------------------------------------------
// pcrc_back: remainder datapath and result sequencer
// Runs the shift/XOR division step, appends the remainder after the last
// encode bit, reports the check verdict, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrc_back
#(
    parameter int MAX_DEGREE = 32
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [pcrc_pkg::GEN_W-1:0]      generator_low,
    input  wire logic [pcrc_pkg::DEGREE_W-1:0]   degree,
    input  wire logic                            q_valid,
    output logic                                 q_ready,
    input  wire pcrc_pkg::cmd_t                  q_cmd,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output pcrc_pkg::out_t                       res_data
);

    localparam int DW = $clog2(MAX_DEGREE + 1);

    localparam logic [1:0] ST_BIT  = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;
    logic [DW-1:0]         cnt_reg;
    logic [DW-1:0]         cnt_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    pcrc_pkg::out_t        res_data_reg;
    pcrc_pkg::out_t        res_data_next;

    logic [DW-1:0]         d_eff;
    logic [63:0]           gen_wide;
    logic [MAX_DEGREE-1:0] gen_masked;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] top_sel;
    logic [MAX_DEGREE-1:0] emit_sel;
    logic [MAX_DEGREE-1:0] rem_masked;
    logic [MAX_DEGREE-1:0] step_res;
    logic                  step_bit;
    logic                  top_bit;
    logic                  emit_bit;
    logic                  adv;

    // Clamp degree into 1..MAX_DEGREE
    always_comb
    begin
        if (degree == '0)
        begin
            d_eff = DW'(1);
        end
        else if ({1'b0, degree} > 7'(MAX_DEGREE))
        begin
            d_eff = DW'(MAX_DEGREE);
        end
        else
        begin
            d_eff = DW'(degree);
        end
    end

    assign gen_wide = {32'd0, generator_low};

    always_comb
    begin
        for (int i = 0; i < MAX_DEGREE; i++)
        begin
            mask[i]     = (i < int'(d_eff));
            top_sel[i]  = (i == int'(d_eff) - 1);
            emit_sel[i] = (i == int'(cnt_reg) - 1);
        end
    end

    assign gen_masked = gen_wide[MAX_DEGREE-1:0] & mask;
    assign rem_masked = rem_reg & mask;
    assign top_bit    = |(rem_masked & top_sel);
    assign emit_bit   = |(rem_reg & emit_sel);
    assign step_bit   = (state_reg == ST_ZERO) ? 1'b0 : q_cmd.data_bit;

    // One division step: shift in at the bottom, fold in generator on carry
    always_comb
    begin
        step_res = ((rem_masked << 1) | MAX_DEGREE'(step_bit)) & mask;
        if (top_bit)
        begin
            step_res = step_res ^ gen_masked;
        end
    end

    assign adv = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        q_ready        = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;

        unique case (state_reg)
            ST_BIT:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        pcrc_pkg::KIND_ECHO:
                        begin
                            if (adv)
                            begin
                                q_ready        = 1'b1;
                                rem_next       = step_res;
                                res_valid_next = 1'b1;
                                res_data_next  = '{q_cmd.data_bit, 1'b0, 1'b0, 1'b0};
                            end
                        end
                        pcrc_pkg::KIND_ECHO_LAST:
                        begin
                            if (adv)
                            begin
                                q_ready        = 1'b1;
                                rem_next       = step_res;
                                res_valid_next = 1'b1;
                                res_data_next  = '{q_cmd.data_bit, 1'b0, 1'b0, 1'b0};
                                cnt_next       = d_eff;
                                state_next     = ST_ZERO;
                            end
                        end
                        pcrc_pkg::KIND_CHECK:
                        begin
                            q_ready  = 1'b1;
                            rem_next = step_res;
                        end
                        default:
                        begin
                            if (adv)
                            begin
                                q_ready        = 1'b1;
                                rem_next       = '0;
                                res_valid_next = 1'b1;
                                res_data_next  = '{1'b0, 1'b0, (step_res == '0), 1'b1};
                            end
                        end
                    endcase
                end
            end
            ST_ZERO:
            begin
                // Append degree zeros, one per cycle
                rem_next = step_res;
                cnt_next = cnt_reg - DW'(1);
                if (cnt_reg == DW'(1))
                begin
                    cnt_next   = d_eff;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = '{emit_bit, 1'b1, 1'b0, (cnt_reg == DW'(1))};
                    cnt_next       = cnt_reg - DW'(1);
                    if (cnt_reg == DW'(1))
                    begin
                        rem_next   = '0;
                        state_next = ST_BIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_BIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BIT;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/programmable_crc_encode_check.sv @@
// ----------------------------------------------------------------------------
// programmable_crc_encode_check: bit-serial CRC encoder and checker
// Divides a bit stream by a programmable generator (leading one implied);
// encode echoes bits and appends the remainder, check reports a zero test.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  bit       sink       bit_valid/bit_ready    bit_data  (data_bit, last_bit)
//  res       source     res_valid/res_ready    res_data  (out_bit, is_remainder,
//                                                         check_ok, frame_end)
//  cfg       sink       cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One bit per cycle enters while the queue has room and is divided by the
//  shift/XOR step. The last bit in encode mode holds the divider while it
//  appends degree zeros and then emits the degree remainder bits. A two-entry
//  queue splits intake from the divider; while a result waits in the result
//  register, only check bits and appended zeros advance the divider. Reset
//  clears the remainder and loads generator 7, degree 8, encode mode.
// ----------------------------------------------------------------------------
`default_nettype none

module programmable_crc_encode_check
#(
    parameter int MAX_DEGREE = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          bit_valid,
    output logic               bit_ready,
    input  wire pcrc_pkg::in_t bit_data,
    output logic               res_valid,
    input  wire logic          res_ready,
    output pcrc_pkg::out_t     res_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    logic [pcrc_pkg::GEN_W-1:0]    generator_low_reg;
    logic [pcrc_pkg::DEGREE_W-1:0] degree_reg;
    logic                          mode_reg;
    logic                          cfg_write;
    logic                          q_valid;
    logic                          q_ready;
    pcrc_pkg::cmd_t                q_cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generator_low_reg <= pcrc_pkg::GEN_RESET;
            degree_reg        <= pcrc_pkg::DEGREE_RESET;
            mode_reg          <= pcrc_pkg::MODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcrc_pkg::CFG_GENERATOR_LOW: generator_low_reg <= cfg_data;
                pcrc_pkg::CFG_DEGREE:        degree_reg <= cfg_data[pcrc_pkg::DEGREE_W-1:0];
                pcrc_pkg::CFG_MODE:          mode_reg <= cfg_data[0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    pcrc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .bit_valid (bit_valid),
        .bit_ready (bit_ready),
        .bit_data  (bit_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd)
    );

    pcrc_back
    #(
        .MAX_DEGREE (MAX_DEGREE)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .generator_low (generator_low_reg),
        .degree        (degree_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data)
    );

endmodule

`default_nettype wire
